// ===== sv/jlf_pkg.sv =====
// Jump label fixup package: widths, codes, item and control structs,
// and the countdown reload function. No dependencies.
`default_nettype none
package jlf_pkg;

  localparam int LABEL_SLOTS = 256;
  localparam int LABEL_BITS  = $clog2(LABEL_SLOTS);
  localparam int MAX_PROGRAM = 4096;
  localparam int POS_W       = 12;
  localparam int LEN_W       = 13;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [15:0] OP_JUMP_ALWAYS = 16'h0005;

  localparam logic [LEN_W-1:0]      LENGTH_RESET = 13'd1;
  localparam logic [15:0]           JUMP_MARKER_RESET  = 16'hffff;
  localparam logic [15:0]           LABEL_MARKER_RESET = 16'hfefe;

  localparam logic [CFG_IDX_W-1:0] REG_PROGRAM_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_MARKER    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LABEL_MARKER   = 2'd2;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_UNRESOLVED = 3'd1,
    ST_DUPLICATE  = 3'd2,
    ST_BAD_INDEX  = 3'd3,
    ST_BAD_LENGTH = 3'd4
  } status_t;

  typedef struct packed {
    logic [15:0] opcode;
    logic [7:0]  true_offset;
    logic [7:0]  false_offset;
    logic [31:0] operand_word;
  } item_t;

  typedef struct packed {
    logic [15:0]      opcode;
    logic [7:0]       true_offset;
    logic [7:0]       false_offset;
    logic [31:0]      operand_word;
    logic [POS_W-1:0] position;
    status_t          status;
    logic             program_done;
  } result_t;

  typedef struct packed {
    logic                  advance;
    logic                  restart;
    logic                  set_known;
    logic [LABEL_BITS-1:0] addr;
    logic [POS_W-1:0]      pos;
    logic                  raise;
    status_t               err;
  } update_t;

  function automatic logic length_bad(input logic [LEN_W-1:0] len);
    return (len == '0) || (32'(len) > 32'(MAX_PROGRAM));
  endfunction

  function automatic logic [POS_W-1:0] reload(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] m;
    m = len - LEN_W'(1);
    return length_bad(len) ? '0 : m[POS_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/jlf_label_ram.sv =====
// Label position store: one write port, one registered read port.
// No dependencies.
`default_nettype none
module jlf_label_ram #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 12
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/jlf_resolve.sv =====
// Per-item fixup decision: classify the instruction, patch it and derive
// the label table and error updates. Depends on jlf_pkg.
`default_nettype none
module jlf_resolve (
  input  wire jlf_pkg::item_t                   item,
  input  wire logic [jlf_pkg::POS_W-1:0]        label_pos,
  input  wire logic                             known,
  input  wire jlf_pkg::status_t                 sticky_error,
  input  wire logic [jlf_pkg::POS_W-1:0]        countdown,
  input  wire logic [jlf_pkg::LEN_W-1:0]        program_length,
  input  wire logic [15:0]                      jump_marker,
  input  wire logic [15:0]                      label_marker,
  output jlf_pkg::result_t                      res,
  output jlf_pkg::update_t                      upd
);

  logic [15:0] pair;
  logic        is_jump;
  logic        is_label;
  logic        idx_bad;
  logic [31:0] jump_dist;

  assign pair      = {item.true_offset, item.false_offset};
  assign is_jump   = (item.opcode == jlf_pkg::OP_JUMP_ALWAYS) && (pair == jump_marker);
  assign is_label  = (item.opcode == jlf_pkg::OP_JUMP_ALWAYS) && (pair == label_marker);
  assign idx_bad   = (item.operand_word[31:jlf_pkg::LABEL_BITS] != '0);
  assign jump_dist = 32'(label_pos) - 32'(countdown) - 32'd1;

  always_comb begin
    res.opcode       = item.opcode;
    res.true_offset  = item.true_offset;
    res.false_offset = item.false_offset;
    res.operand_word = item.operand_word;
    res.position     = countdown;
    res.status       = jlf_pkg::ST_OK;
    res.program_done = (countdown == '0);

    upd.advance   = 1'b1;
    upd.restart   = (countdown == '0);
    upd.set_known = 1'b0;
    upd.addr      = item.operand_word[jlf_pkg::LABEL_BITS-1:0];
    upd.pos       = countdown;
    upd.raise     = 1'b0;
    upd.err       = jlf_pkg::ST_OK;

    if (jlf_pkg::length_bad(program_length)) begin
      res.position     = '0;
      res.status       = jlf_pkg::ST_BAD_LENGTH;
      res.program_done = 1'b0;
      upd.advance      = 1'b0;
      upd.restart      = 1'b0;
    end else if (sticky_error != jlf_pkg::ST_OK) begin
      res.status = sticky_error;
    end else if (is_jump || is_label) begin
      if (idx_bad) begin
        res.status = jlf_pkg::ST_BAD_INDEX;
      end else if (is_jump) begin
        if (!known) begin
          res.status = jlf_pkg::ST_UNRESOLVED;
        end else begin
          res.operand_word = jump_dist;
          res.true_offset  = '0;
          res.false_offset = '0;
        end
      end else if (known) begin
        res.status = jlf_pkg::ST_DUPLICATE;
      end else begin
        upd.set_known    = 1'b1;
        res.operand_word = '0;
        res.true_offset  = '0;
        res.false_offset = '0;
      end
      upd.raise = (res.status != jlf_pkg::ST_OK);
      upd.err   = res.status;
    end
  end

endmodule
`default_nettype wire

// ===== sv/jump_label_fixup.sv =====
// Jump label fixup top level: input register, label store, fixup logic
// and result register. Depends on jlf_pkg, jlf_label_ram, jlf_resolve.
//
//   channel   handshake            payload
//   input     start / busy         opcode, true_offset, false_offset, operand_word
//   result    result_valid         out_*, position, status, program_done
//   config    cfg_we               cfg_index, cfg_data
//
// One item per cycle; each item passes the input register and then the result register.
// The rate is set by the label store: one read and one write per cycle, with
// a write from the item ahead forwarded to the read of the next.
// Synchronous reset clears the label marks, the error and the countdown.
// busy stays low; results cannot be held off and show for one cycle each.
`default_nettype none
module jump_label_fixup (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [15:0]                       opcode,
  input  wire logic [7:0]                        true_offset,
  input  wire logic [7:0]                        false_offset,
  input  wire logic [31:0]                       operand_word,
  input  wire logic                              cfg_we,
  input  wire logic [jlf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [jlf_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                   result_valid,
  output logic [15:0]                            out_opcode,
  output logic [7:0]                             out_true_offset,
  output logic [7:0]                             out_false_offset,
  output logic [31:0]                            out_operand_word,
  output logic [jlf_pkg::POS_W-1:0]              position,
  output logic [2:0]                             status,
  output logic                                   program_done
);

  logic [jlf_pkg::LEN_W-1:0]       program_length;
  logic [15:0]                     jump_marker;
  logic [15:0]                     label_marker;
  logic [jlf_pkg::LABEL_SLOTS-1:0] label_known;
  logic [jlf_pkg::POS_W-1:0]       countdown;
  jlf_pkg::status_t                sticky_error;

  logic                            s1_valid;
  jlf_pkg::item_t                  s1_item;
  logic                            fwd_hit;
  logic [jlf_pkg::POS_W-1:0]       fwd_pos;
  logic [jlf_pkg::POS_W-1:0]       ram_rdata;
  logic [jlf_pkg::POS_W-1:0]       label_pos;

  jlf_pkg::result_t                res;
  jlf_pkg::result_t                res_q;
  jlf_pkg::update_t                upd;
  logic                            mem_we;
  logic                            accept;
  logic [jlf_pkg::LEN_W-1:0]       new_length;

  assign busy       = 1'b0;
  assign accept     = start && !busy;
  assign mem_we     = s1_valid && upd.set_known;
  assign label_pos  = fwd_hit ? fwd_pos : ram_rdata;
  assign new_length = cfg_data[jlf_pkg::LEN_W-1:0];

  jlf_label_ram #(
    .DEPTH  (jlf_pkg::LABEL_SLOTS),
    .ADDR_W (jlf_pkg::LABEL_BITS),
    .DATA_W (jlf_pkg::POS_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (upd.addr),
    .wdata (upd.pos),
    .raddr (operand_word[jlf_pkg::LABEL_BITS-1:0]),
    .rdata (ram_rdata)
  );

  jlf_resolve u_resolve (
    .item           (s1_item),
    .label_pos      (label_pos),
    .known          (label_known[s1_item.operand_word[jlf_pkg::LABEL_BITS-1:0]]),
    .sticky_error   (sticky_error),
    .countdown      (countdown),
    .program_length (program_length),
    .jump_marker    (jump_marker),
    .label_marker   (label_marker),
    .res            (res),
    .upd            (upd)
  );

  // input stage, store forwarding and result register
  always_ff @(posedge clk) begin
    s1_item <= '{opcode, true_offset, false_offset, operand_word};
    fwd_hit <= mem_we && (upd.addr == operand_word[jlf_pkg::LABEL_BITS-1:0]);
    fwd_pos <= upd.pos;
    res_q   <= res;
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_valid     <= accept;
      result_valid <= s1_valid;
    end
  end

  // configuration and program state
  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= jlf_pkg::LENGTH_RESET;
      jump_marker    <= jlf_pkg::JUMP_MARKER_RESET;
      label_marker   <= jlf_pkg::LABEL_MARKER_RESET;
      label_known    <= '0;
      sticky_error   <= jlf_pkg::ST_OK;
      countdown      <= jlf_pkg::reload(jlf_pkg::LENGTH_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        jlf_pkg::REG_PROGRAM_LENGTH: begin
          program_length <= new_length;
          label_known    <= '0;
          sticky_error   <= jlf_pkg::ST_OK;
          countdown      <= jlf_pkg::reload(new_length);
        end
        jlf_pkg::REG_JUMP_MARKER: begin
          jump_marker <= cfg_data;
        end
        jlf_pkg::REG_LABEL_MARKER: begin
          label_marker <= cfg_data;
        end
        default: begin
        end
      endcase
    end else if (s1_valid && upd.advance) begin
      if (upd.restart) begin
        label_known  <= '0;
        sticky_error <= jlf_pkg::ST_OK;
        countdown    <= jlf_pkg::reload(program_length);
      end else begin
        countdown <= countdown - jlf_pkg::POS_W'(1);
        if (upd.set_known) begin
          label_known[upd.addr] <= 1'b1;
        end
        if (upd.raise) begin
          sticky_error <= upd.err;
        end
      end
    end
  end

  assign out_opcode       = res_q.opcode;
  assign out_true_offset  = res_q.true_offset;
  assign out_false_offset = res_q.false_offset;
  assign out_operand_word = res_q.operand_word;
  assign position         = res_q.position;
  assign status           = res_q.status;
  assign program_done     = res_q.program_done;

endmodule
`default_nettype wire
